// File: sv/tve_pkg.sv
// Shared types, codes and constants of the track velocity extrapolator.
package tve_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W = 33;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_UPDATE  = 2'd1;
    localparam logic [1:0] OP_PREDICT = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_VEL_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ELAPSED = 1'd1;

    localparam logic [15:0] VEL_LIMIT_RST   = 16'd1000;
    localparam logic [7:0]  MIN_ELAPSED_RST = 8'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] trk_id;
        logic [7:0]  obj_id;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] box_w;
        logic [15:0] box_h;
        logic [31:0] stamp;
        logic        frame_end;
    } in_t;

    typedef struct packed {
        logic [15:0] out_track;
        logic [7:0]  out_class;
        logic [15:0] pred_x;
        logic [15:0] pred_y;
        logic [15:0] out_w;
        logic [15:0] out_h;
        logic        is_last;
    } out_t;

    typedef struct packed {
        logic [15:0]        trk;
        logic [7:0]         cls;
        logic [15:0]        x;
        logic [15:0]        y;
        logic [15:0]        w;
        logic [15:0]        h;
        logic [31:0]        t;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } entry_t;

    typedef struct packed {
        logic [15:0]        trk;
        logic [7:0]         cls;
        logic [15:0]        x;
        logic [15:0]        y;
        logic [15:0]        w;
        logic [15:0]        h;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } shadow_t;

    typedef struct packed {
        logic latch;
        logic shadow_load;
        logic idx_clr;
        logic idx_inc;
        logic k_clr;
        logic k_inc;
        logic ent_rd;
        logic ent_addr_k;
        logic sh_rd;
        logic sh_wb;
        logic div_start;
        logic ent_upd;
        logic cp_wr;
        logic fin_frame;
        logic dt_ld;
        logic mul_en;
        logic mul_y;
        logic mul_hi;
        logic pred_x_ld;
        logic out_ld;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       fend;
        logic       idx_end;
        logic       k_end;
        logic       key_eq;
        logic       dt_small;
        logic       div_done;
        logic       ent_empty;
        logic       is_last;
        logic       out_taken;
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FE_NEXT,
        ST_FE_RD,
        ST_SR_RD,
        ST_SR_CHK,
        ST_SR_DIV,
        ST_SR_POST,
        ST_SR_FIN,
        ST_CP_RD,
        ST_CP_WR,
        ST_P_RD,
        ST_P_DT,
        ST_P_MX0,
        ST_P_MX1,
        ST_P_MY0,
        ST_P_MY1,
        ST_P_LOAD,
        ST_P_WAIT
    } state_t;

endpackage

// File: sv/tve_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module tve_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tve_pkg::DIV_W-1:0] num,
    input  logic [tve_pkg::DIV_W-1:0] den,
    output logic                      done,
    output logic [tve_pkg::DIV_W-1:0] quo
);

    localparam int W = tve_pkg::DIV_W;

    logic         busy_reg;
    logic [5:0]   cnt_reg;
    logic [W:0]   rem_reg;
    logic [W-1:0] quo_reg;
    logic [W-1:0] den_reg;
    logic [W:0]   trial;
    logic         fits;

    assign trial = {rem_reg[W-1:0], quo_reg[W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done = !busy_reg;
    assign quo  = quo_reg;

endmodule

// File: sv/tve_datapath.sv
// Datapath: track tables, search counters, dividers and extrapolation multiplier.
module tve_datapath #(
    parameter int TRACKS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tve_pkg::in_t                     in_data,
    output tve_pkg::out_t                    out_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             cfg_we,
    input  logic [tve_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tve_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  tve_pkg::cmd_t                    cmd,
    output tve_pkg::status_t                 status
);

    localparam int CW = $clog2(TRACKS + 1);
    localparam int IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    tve_pkg::entry_t  ent_mem [TRACKS];
    tve_pkg::shadow_t sh_mem  [TRACKS];

    tve_pkg::in_t     in_reg;
    tve_pkg::entry_t  ent_reg;
    tve_pkg::shadow_t sh_reg;
    tve_pkg::out_t    out_reg;
    logic             out_valid_reg;

    logic [15:0] vel_limit_reg;
    logic [7:0]  min_elapsed_reg;

    logic [CW-1:0] entry_count_reg;
    logic [CW-1:0] shadow_count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] k_reg;

    logic               hit_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic               negx_reg;
    logic               negy_reg;

    logic signed [32:0] dt_reg;
    logic signed [65:0] acc_reg;
    logic [15:0]        pred_x_reg;

    // detection being matched: the input item on update, a shadow row on frame end
    logic        upd_mode;
    logic [15:0] det_trk;
    logic [7:0]  det_cls;
    logic [15:0] det_x;
    logic [15:0] det_y;

    assign upd_mode = in_reg.op == tve_pkg::OP_UPDATE;
    assign det_trk  = upd_mode ? in_reg.trk_id   : sh_reg.trk;
    assign det_cls  = upd_mode ? in_reg.obj_id   : sh_reg.cls;
    assign det_x    = upd_mode ? in_reg.pos_x    : sh_reg.x;
    assign det_y    = upd_mode ? in_reg.pos_y    : sh_reg.y;

    // elapsed time and division operands for the current match
    logic signed [32:0] dt_now;
    logic [32:0]        dt_mag;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]        dx_mag;
    logic [16:0]        dy_mag;

    assign dt_now = $signed({1'b0, in_reg.stamp}) - $signed({1'b0, ent_reg.t});
    assign dt_mag = dt_now[32] ? 33'(-dt_now) : dt_now;
    assign dx     = $signed({1'b0, det_x}) - $signed({1'b0, ent_reg.x});
    assign dy     = $signed({1'b0, det_y}) - $signed({1'b0, ent_reg.y});
    assign dx_mag = dx[16] ? 17'(-dx) : dx;
    assign dy_mag = dy[16] ? 17'(-dy) : dy;

    logic               divx_done;
    logic               divy_done;
    logic [32:0]        quox;
    logic [32:0]        quoy;

    tve_div u_divx (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({1'b0, dx_mag[15:0], 16'd0}),
        .den   (dt_mag),
        .done  (divx_done),
        .quo   (quox)
    );

    tve_div u_divy (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({1'b0, dy_mag[15:0], 16'd0}),
        .den   (dt_mag),
        .done  (divy_done),
        .quo   (quoy)
    );

    // saturate to 32 bits, halve on a sign reversal, restore the sign
    function automatic logic signed [31:0] fix_rate(
        input logic [32:0]        mag,
        input logic               neg,
        input logic signed [31:0] ref_v
    );
        logic [31:0] m;
        logic        flip;
        begin
            if (neg)
            begin
                m = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : mag[31:0];
            end
            else
            begin
                m = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            end
            flip = (m != 32'd0) &&
                   ((neg && !ref_v[31] && ref_v != 32'sd0) || (!neg && ref_v[31]));
            if (flip)
            begin
                m = m >> 1;
            end
            fix_rate = neg ? $signed(-m) : $signed(m);
        end
    endfunction

    logic signed [31:0] nx_raw;
    logic signed [31:0] ny_raw;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [31:0]        lim;
    logic               over;

    assign nx_raw = fix_rate(quox, negx_reg, ent_reg.vx);
    assign ny_raw = fix_rate(quoy, negy_reg, ent_reg.vy);
    assign lim    = {vel_limit_reg, 16'd0};
    assign over   = (!nx_raw[31] && nx_raw > lim) || (!ny_raw[31] && ny_raw > lim);
    assign nx     = over ? 32'sd0 : nx_raw;
    assign ny     = over ? 32'sd0 : ny_raw;

    // extrapolation: velocity times elapsed time in two 32 x 17 partial products
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] prod;
    logic [15:0]        mul_p;
    logic signed [65:0] acc_next;

    assign mul_a = cmd.mul_y ? ent_reg.vy : ent_reg.vx;
    assign mul_b = cmd.mul_hi ? dt_reg[32:16] : $signed({1'b0, dt_reg[15:0]});
    assign prod  = mul_a * mul_b;
    assign mul_p = cmd.mul_y ? ent_reg.y : ent_reg.x;

    always_comb
    begin
        if (cmd.mul_hi)
        begin
            acc_next = acc_reg + (66'(prod) <<< 16);
        end
        else
        begin
            acc_next = $signed({34'd0, mul_p, 16'd0}) + 66'(prod);
        end
    end

    function automatic logic [15:0] clamp_pos(input logic signed [65:0] s);
        begin
            if (s[65] || s == 66'sd0)
            begin
                clamp_pos = 16'd0;
            end
            else if (|s[64:32])
            begin
                clamp_pos = 16'hFFFF;
            end
            else
            begin
                clamp_pos = s[31:16];
            end
        end
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_limit_reg   <= tve_pkg::VEL_LIMIT_RST;
            min_elapsed_reg <= tve_pkg::MIN_ELAPSED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tve_pkg::CFG_VEL_LIMIT:   vel_limit_reg   <= cfg_data;
                tve_pkg::CFG_MIN_ELAPSED: min_elapsed_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg  <= '0;
            shadow_count_reg <= '0;
            idx_reg          <= '0;
            k_reg            <= '0;
            hit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.shadow_load && shadow_count_reg < CW'(TRACKS))
            begin
                shadow_count_reg <= shadow_count_reg + CW'(1);
            end
            if (cmd.fin_frame)
            begin
                entry_count_reg  <= shadow_count_reg;
                shadow_count_reg <= '0;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.k_clr)
            begin
                k_reg   <= '0;
                hit_reg <= 1'b0;
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_reg + CW'(1);
            end
            if (cmd.ent_upd)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            in_reg <= in_data;
        end
        if (cmd.div_start)
        begin
            negx_reg <= dx[16] ^ dt_now[32];
            negy_reg <= dy[16] ^ dt_now[32];
        end
        if (cmd.ent_upd)
        begin
            vx_reg <= nx;
            vy_reg <= ny;
        end
        if (cmd.dt_ld)
        begin
            dt_reg <= dt_now;
        end
        if (cmd.mul_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.pred_x_ld)
        begin
            pred_x_reg <= clamp_pos(acc_reg);
        end
        if (cmd.out_ld)
        begin
            out_reg.out_track <= ent_reg.trk;
            out_reg.out_class <= ent_reg.cls;
            out_reg.pred_x    <= pred_x_reg;
            out_reg.pred_y    <= clamp_pos(acc_reg);
            out_reg.out_w     <= ent_reg.w;
            out_reg.out_h     <= ent_reg.h;
            out_reg.is_last   <= status.is_last;
        end
    end

    // entry table: one read port, one write port
    logic [IW-1:0]   ent_rd_addr;
    logic [IW-1:0]   ent_wr_addr;
    tve_pkg::entry_t ent_wr_data;

    assign ent_rd_addr = cmd.ent_addr_k ? k_reg[IW-1:0] : idx_reg[IW-1:0];
    assign ent_wr_addr = cmd.cp_wr ? idx_reg[IW-1:0] : k_reg[IW-1:0];

    always_comb
    begin
        if (cmd.cp_wr)
        begin
            ent_wr_data.trk = sh_reg.trk;
            ent_wr_data.cls = sh_reg.cls;
            ent_wr_data.x   = sh_reg.x;
            ent_wr_data.y   = sh_reg.y;
            ent_wr_data.w   = sh_reg.w;
            ent_wr_data.h   = sh_reg.h;
            ent_wr_data.t   = in_reg.stamp;
            ent_wr_data.vx  = sh_reg.vx;
            ent_wr_data.vy  = sh_reg.vy;
        end
        else
        begin
            ent_wr_data    = ent_reg;
            ent_wr_data.x  = det_x;
            ent_wr_data.y  = det_y;
            ent_wr_data.t  = in_reg.stamp;
            if (upd_mode)
            begin
                ent_wr_data.vx = nx;
                ent_wr_data.vy = ny;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ent_upd || cmd.cp_wr)
        begin
            ent_mem[ent_wr_addr] <= ent_wr_data;
        end
        if (cmd.ent_rd)
        begin
            ent_reg <= ent_mem[ent_rd_addr];
        end
    end

    // shadow table: filled on load, velocities written back at frame end
    logic [IW-1:0]    sh_wr_addr;
    tve_pkg::shadow_t sh_wr_data;

    assign sh_wr_addr = cmd.sh_wb ? idx_reg[IW-1:0] : shadow_count_reg[IW-1:0];

    always_comb
    begin
        if (cmd.sh_wb)
        begin
            sh_wr_data    = sh_reg;
            sh_wr_data.vx = hit_reg ? vx_reg : 32'sd0;
            sh_wr_data.vy = hit_reg ? vy_reg : 32'sd0;
        end
        else
        begin
            sh_wr_data.trk = in_reg.trk_id;
            sh_wr_data.cls = in_reg.obj_id;
            sh_wr_data.x   = in_reg.pos_x;
            sh_wr_data.y   = in_reg.pos_y;
            sh_wr_data.w   = in_reg.box_w;
            sh_wr_data.h   = in_reg.box_h;
            sh_wr_data.vx  = 32'sd0;
            sh_wr_data.vy  = 32'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sh_wb || (cmd.shadow_load && shadow_count_reg < CW'(TRACKS)))
        begin
            sh_mem[sh_wr_addr] <= sh_wr_data;
        end
        if (cmd.sh_rd)
        begin
            sh_reg <= sh_mem[idx_reg[IW-1:0]];
        end
    end

    // status back to the controller
    assign status.op        = in_reg.op;
    assign status.fend      = in_reg.frame_end;
    assign status.idx_end   = idx_reg == shadow_count_reg;
    assign status.k_end     = k_reg == entry_count_reg;
    assign status.key_eq    = ent_reg.trk == det_trk && ent_reg.cls == det_cls;
    assign status.dt_small  = dt_now == 33'sd0 || dt_mag < {25'd0, min_elapsed_reg};
    assign status.div_done  = divx_done && divy_done;
    assign status.ent_empty = entry_count_reg == '0;
    assign status.is_last   = (idx_reg + CW'(1)) == entry_count_reg;
    assign status.out_taken = out_valid_reg && out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: sv/tve_ctrl.sv
// Controller: sequences load, frame-end matching, table copy, update and predict.
module tve_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tve_pkg::status_t status,
    output tve_pkg::cmd_t    cmd
);

    tve_pkg::state_t state_reg;
    tve_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tve_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tve_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = tve_pkg::ST_DISPATCH;
                end
            end
            tve_pkg::ST_DISPATCH:
            begin
                unique case (status.op)
                    tve_pkg::OP_LOAD:
                    begin
                        cmd.shadow_load = 1'b1;
                        if (status.fend)
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = tve_pkg::ST_FE_NEXT;
                        end
                        else
                        begin
                            state_next = tve_pkg::ST_IDLE;
                        end
                    end
                    tve_pkg::OP_UPDATE:
                    begin
                        cmd.k_clr  = 1'b1;
                        state_next = tve_pkg::ST_SR_RD;
                    end
                    tve_pkg::OP_PREDICT:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = status.ent_empty ? tve_pkg::ST_IDLE : tve_pkg::ST_P_RD;
                    end
                    default: state_next = tve_pkg::ST_IDLE;
                endcase
            end
            tve_pkg::ST_FE_NEXT:
            begin
                if (status.idx_end)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = tve_pkg::ST_CP_RD;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = tve_pkg::ST_FE_RD;
                end
            end
            tve_pkg::ST_FE_RD:
            begin
                cmd.k_clr  = 1'b1;
                state_next = tve_pkg::ST_SR_RD;
            end
            tve_pkg::ST_SR_RD:
            begin
                if (status.k_end)
                begin
                    state_next = tve_pkg::ST_SR_FIN;
                end
                else
                begin
                    cmd.ent_rd     = 1'b1;
                    cmd.ent_addr_k = 1'b1;
                    state_next     = tve_pkg::ST_SR_CHK;
                end
            end
            tve_pkg::ST_SR_CHK:
            begin
                if (!status.key_eq)
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = tve_pkg::ST_SR_RD;
                end
                else if (status.dt_small)
                begin
                    state_next = tve_pkg::ST_SR_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = tve_pkg::ST_SR_DIV;
                end
            end
            tve_pkg::ST_SR_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = tve_pkg::ST_SR_POST;
                end
            end
            tve_pkg::ST_SR_POST:
            begin
                cmd.ent_upd = 1'b1;
                state_next  = tve_pkg::ST_SR_FIN;
            end
            tve_pkg::ST_SR_FIN:
            begin
                if (status.op == tve_pkg::OP_UPDATE)
                begin
                    state_next = tve_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.sh_wb   = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = tve_pkg::ST_FE_NEXT;
                end
            end
            tve_pkg::ST_CP_RD:
            begin
                if (status.idx_end)
                begin
                    cmd.fin_frame = 1'b1;
                    state_next    = tve_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = tve_pkg::ST_CP_WR;
                end
            end
            tve_pkg::ST_CP_WR:
            begin
                cmd.cp_wr   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = tve_pkg::ST_CP_RD;
            end
            tve_pkg::ST_P_RD:
            begin
                cmd.ent_rd = 1'b1;
                state_next = tve_pkg::ST_P_DT;
            end
            tve_pkg::ST_P_DT:
            begin
                cmd.dt_ld  = 1'b1;
                state_next = tve_pkg::ST_P_MX0;
            end
            tve_pkg::ST_P_MX0:
            begin
                cmd.mul_en = 1'b1;
                state_next = tve_pkg::ST_P_MX1;
            end
            tve_pkg::ST_P_MX1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_hi = 1'b1;
                state_next = tve_pkg::ST_P_MY0;
            end
            tve_pkg::ST_P_MY0:
            begin
                cmd.pred_x_ld = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_y     = 1'b1;
                state_next    = tve_pkg::ST_P_MY1;
            end
            tve_pkg::ST_P_MY1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_y  = 1'b1;
                cmd.mul_hi = 1'b1;
                state_next = tve_pkg::ST_P_LOAD;
            end
            tve_pkg::ST_P_LOAD:
            begin
                cmd.out_ld = 1'b1;
                state_next = tve_pkg::ST_P_WAIT;
            end
            tve_pkg::ST_P_WAIT:
            begin
                if (status.out_taken)
                begin
                    if (status.is_last)
                    begin
                        state_next = tve_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = tve_pkg::ST_P_RD;
                    end
                end
            end
            default: state_next = tve_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: sv/track_velocity_extrapolator_top.sv
// Top level of the track velocity extrapolator.
// Input channel (in_valid/in_ready/in_data) takes one operation per transfer:
// a frame-load detection, an update detection or a predict request.
// Output channel (out_valid/out_ready/out_data) gives one box per table entry
// on predict, is_last marking the final one; loads and updates give nothing.
// One item is worked on at a time; in_ready is high only while idle.
// A load detection is written to the shadow table. Closing a frame then, per
// detection, reads its shadow row, searches the table entries by key and, on a
// match, runs the 33-step dividers; then the shadow table is copied into the
// entry table one entry at a time and the frame is finished.
// An update searches the entry table the same way, dividers on a match.
// A predict reads each entry, forms x and y and loads the output box per entry.
// A stalled receiver holds the output register and the sequencer waits.
// Reset empties both tables (counts to zero) and restores velocity_limit to
// 1000 and min_elapsed to 1; table memories are not cleared.
module track_velocity_extrapolator_top #(
    parameter int TRACKS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tve_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tve_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [tve_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tve_pkg::CFG_DATA_W-1:0] cfg_data
);

    tve_pkg::cmd_t    cmd;
    tve_pkg::status_t status;

    tve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tve_datapath #(
        .TRACKS (TRACKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: verif/tve_checker.sv
// Checker for the track velocity extrapolator: own table model, expected boxes, comparison.
`timescale 1ns / 100ps

module tve_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  tve_pkg::in_t                    in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  tve_pkg::out_t                   out_data,
    input  logic                            cfg_we,
    input  logic [tve_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tve_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending
);

    localparam int TRACKS = 32;

    tve_pkg::entry_t  live_tbl[TRACKS];
    tve_pkg::shadow_t shadow_tbl[TRACKS];
    int               live_n;
    int               shadow_n;
    logic [15:0]      vel_limit;
    logic [7:0]       min_gap;
    tve_pkg::out_t    boxes_due[$];

    // Q16.16 rate, saturated, halved on a sign reversal against the prior velocity
    function automatic logic signed [31:0] rate_q16(longint diff, longint dt,
                                                    logic signed [31:0] prior);
        longint q;
        q = (diff * 65536) / dt;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        if ((q < 0 && prior > 0) || (q > 0 && prior < 0))
            q = q / 2;
        return q[31:0];
    endfunction

    function automatic bit track_match(input logic [15:0] trk, input logic [7:0] cls,
                                       input logic [15:0] px, input logic [15:0] py,
                                       input logic [31:0] stamp, output int k_hit,
                                       output logic signed [31:0] nvx,
                                       output logic signed [31:0] nvy);
        longint dt;
        longint adt;
        longint lim;
        nvx = 0;
        nvy = 0;
        k_hit = 0;
        for (int k = 0; k < live_n; k++)
        begin
            if (live_tbl[k].trk != trk || live_tbl[k].cls != cls)
                continue;
            dt = longint'(stamp) - longint'(live_tbl[k].t);
            adt = (dt < 0) ? -dt : dt;
            if (dt == 0 || adt < longint'(min_gap))
                return 0;
            nvx = rate_q16(longint'(px) - longint'(live_tbl[k].x), dt, live_tbl[k].vx);
            nvy = rate_q16(longint'(py) - longint'(live_tbl[k].y), dt, live_tbl[k].vy);
            lim = longint'(vel_limit) * 65536;
            if (longint'(nvx) > lim || longint'(nvy) > lim)
            begin
                nvx = 0;
                nvy = 0;
            end
            k_hit = k;
            live_tbl[k].x = px;
            live_tbl[k].y = py;
            live_tbl[k].t = stamp;
            return 1;
        end
        return 0;
    endfunction

    function automatic logic [15:0] extrapolate(logic [15:0] p, logic signed [31:0] v,
                                                longint dt);
        logic signed [95:0] s;
        logic signed [95:0] vv;
        logic signed [95:0] dd;
        vv = v;
        dd = dt;
        s = $signed({80'd0, p}) <<< 16;
        s = s + vv * dd;
        if (s <= 0)
            return 16'd0;
        s = s >>> 16;
        if (s > 65535)
            return 16'hFFFF;
        return s[15:0];
    endfunction

    task automatic apply_op(tve_pkg::in_t it);
        int                 k;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        tve_pkg::out_t      box;
        longint             dt;
        case (it.op)
            tve_pkg::OP_LOAD:
            begin
                if (shadow_n < TRACKS)
                begin
                    shadow_tbl[shadow_n] = '{trk: it.trk_id, cls: it.obj_id,
                                             x: it.pos_x, y: it.pos_y, w: it.box_w,
                                             h: it.box_h, vx: 0, vy: 0};
                    shadow_n++;
                end
                if (it.frame_end)
                begin
                    for (int i = 0; i < shadow_n; i++)
                    begin
                        if (!track_match(shadow_tbl[i].trk, shadow_tbl[i].cls,
                                         shadow_tbl[i].x, shadow_tbl[i].y, it.stamp,
                                         k, vx, vy))
                        begin
                            vx = 0;
                            vy = 0;
                        end
                        shadow_tbl[i].vx = vx;
                        shadow_tbl[i].vy = vy;
                    end
                    for (int i = 0; i < shadow_n; i++)
                    begin
                        live_tbl[i] = '{trk: shadow_tbl[i].trk, cls: shadow_tbl[i].cls,
                                        x: shadow_tbl[i].x, y: shadow_tbl[i].y,
                                        w: shadow_tbl[i].w, h: shadow_tbl[i].h,
                                        t: it.stamp, vx: shadow_tbl[i].vx,
                                        vy: shadow_tbl[i].vy};
                    end
                    live_n = shadow_n;
                    shadow_n = 0;
                end
            end
            tve_pkg::OP_UPDATE:
            begin
                if (track_match(it.trk_id, it.obj_id, it.pos_x, it.pos_y, it.stamp,
                                k, vx, vy))
                begin
                    live_tbl[k].vx = vx;
                    live_tbl[k].vy = vy;
                end
            end
            tve_pkg::OP_PREDICT:
            begin
                for (int i = 0; i < live_n; i++)
                begin
                    dt = longint'(it.stamp) - longint'(live_tbl[i].t);
                    box.out_track = live_tbl[i].trk;
                    box.out_class = live_tbl[i].cls;
                    box.pred_x    = extrapolate(live_tbl[i].x, live_tbl[i].vx, dt);
                    box.pred_y    = extrapolate(live_tbl[i].y, live_tbl[i].vy, dt);
                    box.out_w     = live_tbl[i].w;
                    box.out_h     = live_tbl[i].h;
                    box.is_last   = (i == live_n - 1);
                    boxes_due.insert(boxes_due.size(), box);
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_box(tve_pkg::out_t got);
        tve_pkg::out_t want;
        if (boxes_due.size() == 0)
        begin
            $display("%0t: unexpected box, exp none got %h", $time, got);
            fail_count++;
            return;
        end
        want = boxes_due.pop_front();
        if (got.out_track !== want.out_track)
            $display("%0t: out_track exp %h got %h", $time, want.out_track, got.out_track);
        if (got.out_class !== want.out_class)
            $display("%0t: out_class exp %h got %h", $time, want.out_class, got.out_class);
        if (got.pred_x !== want.pred_x)
            $display("%0t: pred_x exp %h got %h", $time, want.pred_x, got.pred_x);
        if (got.pred_y !== want.pred_y)
            $display("%0t: pred_y exp %h got %h", $time, want.pred_y, got.pred_y);
        if (got.out_w !== want.out_w)
            $display("%0t: out_w exp %h got %h", $time, want.out_w, got.out_w);
        if (got.out_h !== want.out_h)
            $display("%0t: out_h exp %h got %h", $time, want.out_h, got.out_h);
        if (got.is_last !== want.is_last)
            $display("%0t: is_last exp %b got %b", $time, want.is_last, got.is_last);
        if (got !== want)
            fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_n = 0;
            shadow_n = 0;
            vel_limit = tve_pkg::VEL_LIMIT_RST;
            min_gap = tve_pkg::MIN_ELAPSED_RST;
            boxes_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tve_pkg::CFG_VEL_LIMIT:   vel_limit = cfg_data;
                    tve_pkg::CFG_MIN_ELAPSED: min_gap = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                compare_box(out_data);
            if (in_valid && in_ready)
                apply_op(in_data);
            pending = boxes_due.size();
        end
    end

endmodule

// File: verif/track_velocity_extrapolator_top_tb.sv
// Testbench top: stimulus, handshake idling and verdict for the track velocity extrapolator.
`timescale 1ns / 100ps

module track_velocity_extrapolator_top_tb;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    tve_pkg::in_t                   in_data;
    logic                           out_valid;
    logic                           out_ready;
    tve_pkg::out_t                  out_data;
    logic                           cfg_we;
    logic [tve_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tve_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count;
    int                             pending;

    int          burst_left;
    logic [31:0] now;
    logic [15:0] pool_trk[8];
    logic [7:0]  pool_cls[8];
    logic [15:0] pool_x[8];
    logic [15:0] pool_y[8];
    int          rx_cnt;
    int          rx_mode;

    track_velocity_extrapolator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tve_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

    // receiver: free-running, coin-flip or long-stall pattern, mode redrawn at random from the rx_cnt counter
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cnt <= 0;
            rx_mode <= 0;
        end
        else
        begin
            rx_cnt <= rx_cnt + 1;
            if (rx_cnt % 128 == 127)
                rx_mode <= $urandom_range(0, 2);
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= (rx_cnt % 8 < 2);
            endcase
        end
    end

    function automatic tve_pkg::in_t item(logic [1:0] op, logic [15:0] trk,
                                          logic [7:0] cls, logic [15:0] x,
                                          logic [15:0] y, logic [15:0] w,
                                          logic [15:0] h, logic [31:0] stamp, logic fe);
        tve_pkg::in_t it;
        it = '{op: op, trk_id: trk, obj_id: cls, pos_x: x, pos_y: y, box_w: w,
               box_h: h, stamp: stamp, frame_end: fe};
        return it;
    endfunction

    task automatic push_item(tve_pkg::in_t it);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
    endtask

    // let the block finish: results drained, then time for a silent frame close
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4000) @(posedge clk);
    endtask

    task automatic write_cfg(logic [tve_pkg::CFG_IDX_W-1:0] idx,
                             logic [tve_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic step_clock;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            now = now - $urandom_range(0, 50);
        else if (r < 15)
            now = now + $urandom_range(100, 700);
        else
            now = now + $urandom_range(0, 30);
    endtask

    task automatic move_pool(int p);
        if ($urandom_range(0, 19) == 0)
        begin
            pool_x[p] = 16'($urandom);
            pool_y[p] = 16'($urandom);
        end
        else
        begin
            pool_x[p] = pool_x[p] + 16'($urandom_range(0, 60)) - 16'd30;
            pool_y[p] = pool_y[p] + 16'($urandom_range(0, 60)) - 16'd30;
        end
    endtask

    task automatic run_random(int count);
        int issued;
        int kind;
        int n;
        int p;
        issued = 0;
        while (issued < count)
        begin
            kind = $urandom_range(0, 99);
            step_clock();
            if (kind < 50)
            begin
                n = $urandom_range(1, 6);
                for (int j = 0; j < n; j++)
                begin
                    p = $urandom_range(0, 7);
                    move_pool(p);
                    if ($urandom_range(0, 9) == 0)
                        push_item(item(tve_pkg::OP_LOAD, 16'($urandom), 8'($urandom),
                                       16'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom), $urandom, j == n - 1));
                    else
                        push_item(item(tve_pkg::OP_LOAD, pool_trk[p], pool_cls[p],
                                       pool_x[p], pool_y[p], 16'($urandom), 16'($urandom),
                                       (j == n - 1) ? now : $urandom, j == n - 1));
                end
                issued += n;
            end
            else if (kind < 72)
            begin
                p = $urandom_range(0, 7);
                move_pool(p);
                push_item(item(tve_pkg::OP_UPDATE, pool_trk[p], pool_cls[p], pool_x[p],
                               pool_y[p], 16'($urandom), 16'($urandom), now,
                               1'($urandom_range(0, 1))));
                issued++;
            end
            else if (kind < 94)
            begin
                push_item(item(tve_pkg::OP_PREDICT, 16'($urandom), 8'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                               ($urandom_range(0, 9) == 0) ? $urandom
                                                           : now + $urandom_range(0, 200),
                               1'($urandom_range(0, 1))));
                issued++;
            end
            else
            begin
                // unused opcode, ignored by the block
                push_item(item(tve_pkg::OP_UNUSED, 16'($urandom), 8'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                               $urandom, 1'($urandom_range(0, 1))));
                issued++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = tve_pkg::CFG_VEL_LIMIT;
        cfg_data = '0;
        burst_left = 0;
        now = 32'd1000;
        for (int p = 0; p < 8; p++)
        begin
            pool_trk[p] = (p < 2) ? 16'(p) : 16'($urandom);
            pool_cls[p] = (p == 1) ? 8'd7 : 8'($urandom_range(0, 3));
            pool_x[p] = 16'($urandom_range(100, 60000));
            pool_y[p] = 16'($urandom_range(100, 60000));
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, ignored op, extremes, reversal, limit, clamps
        push_item(item(tve_pkg::OP_PREDICT, 0, 0, 0, 0, 0, 0, 0, 0));
        push_item(item(tve_pkg::OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 32'hFFFF_FFFF, 1));
        push_item(item(tve_pkg::OP_LOAD, 0, 0, 0, 0, 16'hFFFF, 0, 100, 0));
        push_item(item(tve_pkg::OP_LOAD, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF,
                       100, 1));
        push_item(item(tve_pkg::OP_PREDICT, 0, 0, 0, 0, 0, 0, 100, 0));
        push_item(item(tve_pkg::OP_LOAD, 0, 0, 50, 20, 1, 2, 0, 0));
        push_item(item(tve_pkg::OP_LOAD, 16'hFFFF, 8'hFF, 0, 16'hFFFF, 3, 4, 110, 1));
        push_item(item(tve_pkg::OP_PREDICT, 0, 0, 0, 0, 0, 0, 5000, 0));
        push_item(item(tve_pkg::OP_PREDICT, 0, 0, 0, 0, 0, 0, 50, 0));
        push_item(item(tve_pkg::OP_UPDATE, 0, 0, 40, 20, 0, 0, 120, 0));
        push_item(item(tve_pkg::OP_UPDATE, 0, 0, 40, 20, 0, 0, 120, 0));
        push_item(item(tve_pkg::OP_UPDATE, 0, 0, 4000, 21, 0, 0, 121, 0));
        push_item(item(tve_pkg::OP_UPDATE, 16'hFFFF, 8'hFF, 100, 100, 0, 0, 105, 0));
        push_item(item(tve_pkg::OP_UPDATE, 16'hFFFF, 8'h00, 100, 100, 0, 0, 130, 0));
        push_item(item(tve_pkg::OP_PREDICT, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        push_item(item(tve_pkg::OP_LOAD, 0, 0, 60, 20, 5, 6, 0, 0));
        push_item(item(tve_pkg::OP_LOAD, 0, 0, 70, 30, 7, 8, 110, 1));
        push_item(item(tve_pkg::OP_PREDICT, 0, 0, 0, 0, 0, 0, 140, 1));
        drain();

        write_cfg(tve_pkg::CFG_VEL_LIMIT, 16'd0);
        write_cfg(tve_pkg::CFG_MIN_ELAPSED, 16'd0);
        run_random(15);
        drain();

        write_cfg(tve_pkg::CFG_VEL_LIMIT, 16'hFFFF);
        write_cfg(tve_pkg::CFG_MIN_ELAPSED, 16'hFF);
        run_random(15);
        drain();

        write_cfg(tve_pkg::CFG_VEL_LIMIT, tve_pkg::VEL_LIMIT_RST);
        write_cfg(tve_pkg::CFG_MIN_ELAPSED, 16'(tve_pkg::MIN_ELAPSED_RST));
        // oversized frame: detections past the table size are dropped, the close still counts
        for (int j = 0; j < 34; j++)
            push_item(item(tve_pkg::OP_LOAD, 16'(j), 8'(j % 3), 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom), now, j == 33));
        step_clock();
        push_item(item(tve_pkg::OP_PREDICT, 0, 0, 0, 0, 0, 0, now + 5, 0));
        run_random(25);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
